### hw/rtl/msgf_pkg.sv
// ----------------------------------------------------------------------------
// msgf_pkg: shared types and constants for the masked Gaussian depth filter
// Word layouts, register indexes, state encodings and reset values.
// ----------------------------------------------------------------------------
package msgf_pkg;

   localparam int HALF_TAPS_DEF = 3;
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_ROWS      = 1024;
   localparam int ONE_Q15       = 32768;
   localparam int PONDER_MIN    = 3;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_CENTER  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_ONE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_TWO     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_THREE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd5;

   localparam logic [15:0] COEF_CENTER_RST  = 16'd9438;
   localparam logic [15:0] COEF_ONE_RST     = 16'd7314;
   localparam logic [15:0] COEF_TWO_RST     = 16'd3403;
   localparam logic [15:0] COEF_THREE_RST   = 16'd948;
   localparam logic [10:0] FRAME_WIDTH_RST  = 11'd160;
   localparam logic [10:0] FRAME_HEIGHT_RST = 11'd120;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_DRAIN = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [15:0]   depth;
   } req_word_type;

   typedef struct packed {
      logic [15:0] depth_out;
      logic [9:0]  out_row;
      logic [9:0]  out_col;
      logic        frame_last;
   } rsp_word_type;

   typedef struct packed {
      logic clear;
      logic acc;
      logic finish;
   } comb_ctl_type;

   typedef struct packed {
      logic done;
   } comb_sts_type;

   typedef enum logic [3:0] {
      B_IDLE, B_PIX, B_RMAC, B_RFIN, B_RWAIT, B_ECHK, B_EMIT, B_EPASS,
      B_CADDR, B_CMAC, B_CFIN, B_CWAIT, B_ADV
   } back_state_type;

   typedef enum logic [1:0] {
      C_IDLE, C_CHECK, C_DIV, C_DONE
   } comb_state_type;

endpackage

### hw/rtl/msgf_front.sv
// ----------------------------------------------------------------------------
// msgf_front: input queue
// Takes request words, tags pixel or drain, and holds two for the back end.
// ----------------------------------------------------------------------------
module msgf_front import msgf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic         req_func,
   input  logic [15:0]  req_depth_in,
   output logic         req_full,
   output logic         item_valid,
   output req_word_type item,
   input  logic         item_pop
);

   req_word_type buf_ff [2];
   req_word_type buf_in [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;
   req_word_type word;

   always_comb begin
      word.kind  = req_func ? KIND_DRAIN : KIND_PIXEL;
      word.depth = req_depth_in;
   end

   assign req_full   = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = buf_ff[rp_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_pop && item_valid;

   always_comb begin
      buf_in = buf_ff;
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push_ok) begin
         buf_in[wp_ff] = word;
         wp_in = !wp_ff;
      end
      if (pop_ok) begin
         rp_in = !rp_ff;
      end
      case ({push_ok, pop_ok})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### hw/rtl/msgf_comb.sv
// ----------------------------------------------------------------------------
// msgf_comb: masked tap combiner
// Serial multiply-accumulate with weight removal, then round, divide, saturate or give zero.
// ----------------------------------------------------------------------------
module msgf_comb import msgf_pkg::*; #(
   parameter int HALF_TAPS = HALF_TAPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  comb_ctl_type ctl,
   input  logic [15:0]  tap_val,
   input  logic [15:0]  tap_wt,
   output comb_sts_type sts,
   output logic [15:0]  result
);

   localparam int NTAPS = 2 * HALF_TAPS + 1;
   localparam int SW    = 32 + $clog2(NTAPS);
   localparam int PW    = 18 + $clog2(NTAPS);
   localparam int NW    = SW + 2;
   localparam int RW    = 33;

   comb_state_type cst_ff, cst_in;
   logic [31:0]        prod_ff, prod_in;
   logic               pz_ff, pz_in, pv_ff, pv_in;
   logic [15:0]        pw_ff, pw_in;
   logic [SW-1:0]      sum_ff, sum_in;
   logic signed [PW-1:0] pond_ff, pond_in;
   logic [RW-1:0]      rem_ff, rem_in, dsh_ff, dsh_in;
   logic [15:0]        q_ff, q_in, res_ff, res_in;
   logic [3:0]         step_ff, step_in;
   logic [NW-1:0]      num, lim;
   logic [16:0]        den;
   logic [SW-1:0]      rnd;
   logic               ge;

   assign den = {pond_ff[15:0], 1'b0};
   assign num = (NW'(sum_ff) << 1) + NW'(pond_ff[15:0]);
   assign lim = NW'(den) << 16;
   assign rnd = (sum_ff + SW'(ONE_Q15 / 2)) >> 15;
   assign ge  = (rem_ff >= dsh_ff);

   always_comb begin
      cst_in = cst_ff;
      case (cst_ff)
         C_IDLE:  if (ctl.finish) cst_in = C_CHECK;
         C_CHECK: begin
            if (pond_ff != PW'(ONE_Q15) && pond_ff > PW'(PONDER_MIN) && num < lim) begin
               cst_in = C_DIV;
            end else begin
               cst_in = C_DONE;
            end
         end
         C_DIV:   if (step_ff == 4'd0) cst_in = C_DONE;
         C_DONE:  cst_in = C_IDLE;
         default: cst_in = C_IDLE;
      endcase
   end

   always_comb begin
      prod_in = 32'(tap_val) * 32'(tap_wt);
      pz_in   = (tap_val == 16'd0);
      pw_in   = tap_wt;
      pv_in   = ctl.acc;
      sum_in  = sum_ff;
      pond_in = pond_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      step_in = step_ff;
      res_in  = res_ff;
      if (ctl.clear) begin
         sum_in  = '0;
         pond_in = PW'(ONE_Q15);
      end else if (pv_ff) begin
         if (pz_ff) pond_in = pond_ff - $signed(PW'(pw_ff));
         else       sum_in  = sum_ff + SW'(prod_ff);
      end
      case (cst_ff)
         C_CHECK: begin
            if (pond_ff == PW'(ONE_Q15)) begin
               res_in = (rnd[SW-1:16] != '0) ? 16'hFFFF : rnd[15:0];
            end else if (pond_ff > PW'(PONDER_MIN)) begin
               res_in  = 16'hFFFF;
               rem_in  = RW'(num);
               dsh_in  = RW'(den) << 15;
               q_in    = 16'd0;
               step_in = 4'd15;
            end else begin
               res_in = 16'd0;
            end
         end
         C_DIV: begin
            rem_in  = ge ? rem_ff - dsh_ff : rem_ff;
            dsh_in  = dsh_ff >> 1;
            q_in    = {q_ff[14:0], ge};
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) res_in = {q_ff[14:0], ge};
         end
         default: ;
      endcase
   end

   assign sts.done = (cst_ff == C_DONE);
   assign result   = res_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pz_ff   <= pz_in;
      pw_ff   <= pw_in;
      sum_ff  <= sum_in;
      pond_ff <= pond_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      res_ff  <= res_in;
      if (reset) begin
         cst_ff <= C_IDLE;
         pv_ff  <= 1'b0;
      end else begin
         cst_ff <= cst_in;
         pv_ff  <= pv_in;
      end
   end

endmodule

### hw/rtl/msgf_back.sv
// ----------------------------------------------------------------------------
// msgf_back: filter sequencer
// Row window, line store, row and column passes, output queue, registers.
// ----------------------------------------------------------------------------
module msgf_back import msgf_pkg::*; #(
   parameter int HALF_TAPS = HALF_TAPS_DEF,
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data,
   input  logic                   item_valid,
   input  req_word_type           item,
   output logic                   item_pop,
   output comb_ctl_type           comb_ctl,
   output logic [15:0]            tap_val,
   output logic [15:0]            tap_wt,
   input  comb_sts_type           comb_sts,
   input  logic [15:0]            comb_res,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output rsp_word_type           rsp_word
);

   localparam int NTAPS = 2 * HALF_TAPS + 1;
   localparam int DEPTH = NTAPS * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int XW    = (WW + 2 > 12) ? WW + 2 : 12;
   localparam int RMW   = $clog2(NTAPS);
   localparam int TW    = $clog2(NTAPS);

   back_state_type state_ff, state_in;
   item_kind_type  kind_ff, kind_in;
   logic [15:0]    depth_ff, depth_in;
   logic [15:0]    win_ff [NTAPS];
   logic [15:0]    win_in [NTAPS];
   logic [15:0]    coef_ff [4];
   logic [15:0]    coef_in [4];
   logic [10:0]    fw_ff, fw_in, fh_ff, fh_in;
   logic [CW-1:0]  in_col_ff, in_col_in, em_col_ff, em_col_in;
   logic [9:0]     in_row_ff, in_row_in;
   logic [10:0]    em_row_ff, em_row_in;
   logic [RMW-1:0] in_rm_ff, in_rm_in, em_rm_ff, em_rm_in, trm_ff, trm_in;
   logic [TW-1:0]  tap_ff, tap_in;
   logic           frame_in_ff, frame_in_in;

   logic [15:0]    mem [DEPTH];
   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [15:0]    wr_data, rd_ff;

   rsp_word_type   ofifo_ff [2];
   rsp_word_type   ofifo_in [2];
   logic           owp_ff, owp_in, orp_ff, orp_in;
   logic [1:0]     ocnt_ff, ocnt_in;
   logic           push, opop;
   rsp_word_type   push_word;

   logic [XW-1:0]  w_eff, fwx, in_colx, em_colx;
   logic [10:0]    h_eff;
   logic           is_edge, row_due, col_last, row_last, emit_due, interior, em_last;
   logic           drain_ok, restart;
   logic [RMW-1:0] rm_start;

   function automatic logic [AW-1:0] slot(input logic [RMW-1:0] rm, input logic [CW-1:0] col);
      return AW'(rm) * AW'(MAX_WIDTH) + AW'(col);
   endfunction

   function automatic logic [RMW-1:0] rm_next(input logic [RMW-1:0] rm);
      return (rm == RMW'(NTAPS - 1)) ? '0 : RMW'(rm + 1'b1);
   endfunction

   function automatic logic [1:0] tap_dist(input logic [TW-1:0] t);
      if (t >= TW'(HALF_TAPS)) return 2'(t - TW'(HALF_TAPS));
      else                     return 2'(TW'(HALF_TAPS) - t);
   endfunction

   assign fwx     = XW'(fw_ff);
   assign w_eff   = (fwx < XW'(NTAPS)) ? XW'(NTAPS) :
                    (fwx > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : fwx;
   assign h_eff   = (fh_ff == 11'd0) ? 11'd1 :
                    (fh_ff > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : fh_ff;
   assign in_colx = XW'(in_col_ff);
   assign em_colx = XW'(em_col_ff);
   assign is_edge  = (in_colx < XW'(HALF_TAPS)) || (in_colx + XW'(HALF_TAPS) >= w_eff);
   assign row_due  = (in_colx >= XW'(2 * HALF_TAPS));
   assign col_last = (in_colx + XW'(1) >= w_eff);
   assign row_last = (11'(in_row_ff) + 11'd1 >= h_eff);
   assign emit_due = ((in_row_ff > 10'(HALF_TAPS)) ||
                      (in_row_ff == 10'(HALF_TAPS) && in_colx >= XW'(HALF_TAPS))) &&
                     (em_row_ff < h_eff);
   assign interior = (em_row_ff >= 11'(HALF_TAPS)) &&
                     (12'(em_row_ff) + 12'(HALF_TAPS) < 12'(h_eff));
   assign em_last  = (em_row_ff + 11'd1 == h_eff) && (em_colx + XW'(1) == w_eff);
   assign drain_ok = frame_in_ff && (em_row_ff < h_eff);
   assign rm_start = (em_rm_ff >= RMW'(HALF_TAPS)) ? RMW'(em_rm_ff - RMW'(HALF_TAPS)) :
                     RMW'(em_rm_ff + RMW'(NTAPS - HALF_TAPS));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (item_valid && ocnt_ff != 2'd2) begin
               if (item.kind == KIND_PIXEL) state_in = B_PIX;
               else if (drain_ok)           state_in = B_EMIT;
            end
         end
         B_PIX:   state_in = row_due ? B_RMAC : B_ECHK;
         B_RMAC:  if (tap_ff == TW'(NTAPS - 1)) state_in = B_RFIN;
         B_RFIN:  state_in = B_RWAIT;
         B_RWAIT: if (comb_sts.done) state_in = B_ECHK;
         B_ECHK:  state_in = emit_due ? B_EMIT : B_ADV;
         B_EMIT:  state_in = interior ? B_CADDR : B_EPASS;
         B_EPASS: state_in = (kind_ff == KIND_PIXEL) ? B_ADV : B_IDLE;
         B_CADDR: state_in = B_CMAC;
         B_CMAC:  state_in = (tap_ff == TW'(NTAPS - 1)) ? B_CFIN : B_CADDR;
         B_CFIN:  state_in = B_CWAIT;
         B_CWAIT: begin
            if (comb_sts.done) state_in = (kind_ff == KIND_PIXEL) ? B_ADV : B_IDLE;
         end
         B_ADV:   state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      kind_in     = kind_ff;
      depth_in    = depth_ff;
      win_in      = win_ff;
      coef_in     = coef_ff;
      fw_in       = fw_ff;
      fh_in       = fh_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_rm_in    = in_rm_ff;
      em_col_in   = em_col_ff;
      em_row_in   = em_row_ff;
      em_rm_in    = em_rm_ff;
      trm_in      = trm_ff;
      tap_in      = tap_ff;
      frame_in_in = frame_in_ff;
      item_pop    = 1'b0;
      comb_ctl    = '0;
      tap_val     = win_ff[tap_ff];
      tap_wt      = coef_ff[tap_dist(tap_ff)];
      wr_en       = 1'b0;
      wr_addr     = slot(in_rm_ff, in_col_ff);
      wr_data     = depth_ff;
      rd_en       = 1'b0;
      rd_addr     = slot(em_rm_ff, em_col_ff);
      push        = 1'b0;
      restart     = 1'b0;
      push_word.depth_out  = rd_ff;
      push_word.out_row    = em_row_ff[9:0];
      push_word.out_col    = 10'(em_col_ff);
      push_word.frame_last = em_last;
      case (state_ff)
         B_IDLE: begin
            if (item_valid && ocnt_ff != 2'd2) begin
               item_pop = 1'b1;
               kind_in  = item.kind;
               depth_in = item.depth;
               if (item.kind == KIND_PIXEL && frame_in_ff) restart = 1'b1;
            end
         end
         B_PIX: begin
            for (int t = NTAPS - 1; t > 0; t--) win_in[t] = win_ff[t-1];
            win_in[0] = depth_ff;
            wr_en = is_edge;
            if (row_due) begin
               comb_ctl.clear = 1'b1;
               tap_in = '0;
            end
         end
         B_RMAC: begin
            comb_ctl.acc = 1'b1;
            tap_in = TW'(tap_ff + 1'b1);
         end
         B_RFIN:  comb_ctl.finish = 1'b1;
         B_RWAIT: begin
            wr_en   = comb_sts.done;
            wr_addr = slot(in_rm_ff, CW'(in_col_ff - CW'(HALF_TAPS)));
            wr_data = comb_res;
         end
         B_EMIT: begin
            if (interior) begin
               comb_ctl.clear = 1'b1;
               tap_in = '0;
               trm_in = rm_start;
            end else begin
               rd_en = 1'b1;
            end
         end
         B_EPASS: push = 1'b1;
         B_CADDR: begin
            rd_en   = 1'b1;
            rd_addr = slot(trm_ff, em_col_ff);
         end
         B_CMAC: begin
            comb_ctl.acc = 1'b1;
            tap_val = rd_ff;
            tap_in  = TW'(tap_ff + 1'b1);
            trm_in  = rm_next(trm_ff);
         end
         B_CFIN: comb_ctl.finish = 1'b1;
         B_CWAIT: begin
            push_word.depth_out = comb_res;
            push = comb_sts.done;
         end
         B_ADV: begin
            if (col_last) begin
               in_col_in = '0;
               if (row_last) begin
                  in_row_in   = '0;
                  in_rm_in    = '0;
                  frame_in_in = 1'b1;
               end else begin
                  in_row_in = in_row_ff + 10'd1;
                  in_rm_in  = rm_next(in_rm_ff);
               end
            end else begin
               in_col_in = CW'(in_col_ff + 1'b1);
            end
         end
         default: ;
      endcase
      if (push) begin
         if (em_colx + XW'(1) == w_eff) begin
            em_col_in = '0;
            em_row_in = em_row_ff + 11'd1;
            em_rm_in  = rm_next(em_rm_ff);
         end else begin
            em_col_in = CW'(em_col_ff + 1'b1);
         end
         if (em_last && kind_ff == KIND_DRAIN) restart = 1'b1;
      end
      if (csr_valid) begin
         case (csr_index)
            CSR_COEF_CENTER:  coef_in[0] = csr_data;
            CSR_COEF_ONE:     coef_in[1] = csr_data;
            CSR_COEF_TWO:     coef_in[2] = csr_data;
            CSR_COEF_THREE:   coef_in[3] = csr_data;
            CSR_FRAME_WIDTH: begin
               fw_in   = csr_data[10:0];
               restart = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               fh_in   = csr_data[10:0];
               restart = 1'b1;
            end
            default: ;
         endcase
      end
      if (restart) begin
         in_col_in   = '0;
         in_row_in   = '0;
         in_rm_in    = '0;
         em_col_in   = '0;
         em_row_in   = '0;
         em_rm_in    = '0;
         frame_in_in = 1'b0;
      end
   end

   // result queue
   assign opop      = rsp_pop && (ocnt_ff != 2'd0);
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp_word  = ofifo_ff[orp_ff];

   always_comb begin
      ofifo_in = ofifo_ff;
      owp_in   = owp_ff;
      orp_in   = orp_ff;
      if (push) begin
         ofifo_in[owp_ff] = push_word;
         owp_in = !owp_ff;
      end
      if (opop) orp_in = !orp_ff;
      case ({push, opop})
         2'b10:   ocnt_in = ocnt_ff + 2'd1;
         2'b01:   ocnt_in = ocnt_ff - 2'd1;
         default: ocnt_in = ocnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      depth_ff <= depth_in;
      trm_ff   <= trm_in;
      tap_ff   <= tap_in;
      ofifo_ff <= ofifo_in;
      if (reset) begin
         state_ff    <= B_IDLE;
         win_ff      <= '{default: 16'd0};
         coef_ff[0]  <= COEF_CENTER_RST;
         coef_ff[1]  <= COEF_ONE_RST;
         coef_ff[2]  <= COEF_TWO_RST;
         coef_ff[3]  <= COEF_THREE_RST;
         fw_ff       <= FRAME_WIDTH_RST;
         fh_ff       <= FRAME_HEIGHT_RST;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_rm_ff    <= '0;
         em_col_ff   <= '0;
         em_row_ff   <= '0;
         em_rm_ff    <= '0;
         frame_in_ff <= 1'b0;
         owp_ff      <= 1'b0;
         orp_ff      <= 1'b0;
         ocnt_ff     <= 2'd0;
      end else begin
         state_ff    <= state_in;
         win_ff      <= win_in;
         coef_ff     <= coef_in;
         fw_ff       <= fw_in;
         fh_ff       <= fh_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_rm_ff    <= in_rm_in;
         em_col_ff   <= em_col_in;
         em_row_ff   <= em_row_in;
         em_rm_ff    <= em_rm_in;
         frame_in_ff <= frame_in_in;
         owp_ff      <= owp_in;
         orp_ff      <= orp_in;
         ocnt_ff     <= ocnt_in;
      end
   end

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (ocnt_ff != 2'd2))
      else $error("result queue overflow");

   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      comb_sts.done |-> (state_ff == B_RWAIT || state_ff == B_CWAIT))
      else $error("combiner finished with nobody waiting");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RMAC || state_ff == B_CMAC) |-> (tap_ff < TW'(NTAPS)))
      else $error("tap counter out of range");

   a_emit_in_frame: assert property (@(posedge clock) disable iff (reset)
      push |-> (em_row_ff < h_eff))
      else $error("emit past end of frame");

endmodule

### hw/rtl/masked_separable_gaussian_filter_top.sv
// ----------------------------------------------------------------------------
// masked_separable_gaussian_filter_top: masked separable Gaussian depth filter
// Row then column normalized convolution over a streamed depth frame.
//
//   channel  ports                          direction  accept
//   req      req_push/req_full/func,depth   in         push & !full
//   rsp      rsp_pop/rsp_empty/4 fields     out        pop & !empty
//   csr      csr_valid/csr_ready/index,data in         valid & ready
//
// One word at a time: a pixel runs the row and column passes (7-tap by default)
// through one multiply-accumulate, a 16-step divider, and line store reads;
// a drain word runs only the column pass.
// Reset is synchronous; the line store is not cleared.
// A full result queue holds off new request words; csr is always ready.
// ----------------------------------------------------------------------------
module masked_separable_gaussian_filter_top import msgf_pkg::*; #(
   parameter int HALF_TAPS = HALF_TAPS_DEF,
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_func,
   input  logic [15:0]            req_depth_in,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [15:0]            rsp_depth_out,
   output logic [9:0]             rsp_out_row,
   output logic [9:0]             rsp_out_col,
   output logic                   rsp_frame_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data
);

   logic         item_valid, item_pop;
   req_word_type item;
   comb_ctl_type comb_ctl;
   comb_sts_type comb_sts;
   logic [15:0]  tap_val, tap_wt, comb_res;
   rsp_word_type rsp_word;

   assign csr_ready      = 1'b1;
   assign rsp_depth_out  = rsp_word.depth_out;
   assign rsp_out_row    = rsp_word.out_row;
   assign rsp_out_col    = rsp_word.out_col;
   assign rsp_frame_last = rsp_word.frame_last;

   msgf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_func     (req_func),
      .req_depth_in (req_depth_in),
      .req_full     (req_full),
      .item_valid   (item_valid),
      .item         (item),
      .item_pop     (item_pop)
   );

   msgf_comb #(.HALF_TAPS(HALF_TAPS)) u_comb (
      .clock   (clock),
      .reset   (reset),
      .ctl     (comb_ctl),
      .tap_val (tap_val),
      .tap_wt  (tap_wt),
      .sts     (comb_sts),
      .result  (comb_res)
   );

   msgf_back #(.HALF_TAPS(HALF_TAPS), .MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .comb_ctl   (comb_ctl),
      .tap_val    (tap_val),
      .tap_wt     (tap_wt),
      .comb_sts   (comb_sts),
      .comb_res   (comb_res),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_word   (rsp_word)
   );

endmodule
